// ----- design/smp_pkg.sv -----
`timescale 1ns / 1ps

package smp_pkg;

  localparam int SMALL_BLOCK_BYTES = 64;
  localparam int LEN_FIELD_SMALL   = 8;
  localparam int LEN_FIELD_LARGE   = 16;
  localparam int WORD_INDEX_W      = 5;
  localparam logic [7:0] PAD_MARK  = 8'h80;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } ctrl_state_t;

  // What a block being emitted is made of.
  typedef enum logic [1:0] {
    KIND_DATA,   // a full block of message bytes
    KIND_PAD,    // message tail, pad mark and zeros, no room for the length
    KIND_FINAL,  // message tail, pad mark, zeros and the length
    KIND_TAIL    // zeros and the length, after a KIND_PAD block
  } blk_kind_t;

  typedef struct packed {
    blk_kind_t kind;
    logic      accept_byte;
    logic      accept_finish;
    logic      rd_en;
    logic      load;
  } dp_cmd_t;

  typedef struct packed {
    logic blk_full;
    logic need_extra;
    logic out_free;
    logic last_word;
  } dp_status_t;

endpackage

// ----- design/sha_message_padder.sv -----
`timescale 1ns / 1ps

// SHA message padder. A message byte is taken whenever the padder is idle.
// The byte that completes a block, and every finish request, then holds off
// the input while the block goes out of the word buffer's single read port at
// one word per cycle when the output is not stalled. A finish that needs an
// extra block takes two such passes. The buffer is not cleared after reset;
// padding zeros, the 0x80 mark and the bit length are inserted as words are
// read out. hash_mode may be written whenever no block is being sent.
module sha_message_padder #(
  parameter int MAX_BLOCK_BYTES = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        hash_mode,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [7:0]                        data_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [31:0]                       block_word,
  output logic [smp_pkg::WORD_INDEX_W-1:0]  word_index,
  output logic                              init_block,
  output logic                              block_end,
  output logic                              run_end
);
  import smp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  smp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  smp_datapath #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .hash_mode   (hash_mode),
    .data_byte   (data_byte),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .block_word  (block_word),
    .word_index  (word_index),
    .init_block  (init_block),
    .block_end   (block_end),
    .run_end     (run_end)
  );

endmodule

// ----- design/smp_ctrl.sv -----
`timescale 1ns / 1ps

module smp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              req_type,
  input  smp_pkg::dp_status_t status,
  output logic              in_stall,
  output smp_pkg::dp_cmd_t  cmd
);
  import smp_pkg::*;

  ctrl_state_t state, state_next;
  blk_kind_t   kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kind  <= KIND_DATA;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type) begin
            state_next = ST_READ;
            kind_next  = status.need_extra ? KIND_PAD : KIND_FINAL;
          end else if (status.blk_full) begin
            state_next = ST_READ;
            kind_next  = KIND_DATA;
          end
        end
      end
      ST_READ: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (status.out_free && status.last_word) begin
          if (kind == KIND_PAD) begin
            state_next = ST_READ;
            kind_next  = KIND_TAIL;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall          = 1'b1;
    cmd.kind          = kind;
    cmd.accept_byte   = 1'b0;
    cmd.accept_finish = 1'b0;
    cmd.rd_en         = 1'b0;
    cmd.load          = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall          = 1'b0;
        cmd.accept_byte   = in_valid & ~req_type;
        cmd.accept_finish = in_valid & req_type;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_SEND: begin
        cmd.load = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- design/smp_datapath.sv -----
`timescale 1ns / 1ps

module smp_datapath #(
  parameter int MAX_BLOCK_BYTES = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  smp_pkg::dp_cmd_t                  cmd,
  output smp_pkg::dp_status_t               status,
  input  logic                              cfg_valid,
  input  logic [2:0]                        hash_mode,
  input  logic [7:0]                        data_byte,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [31:0]                       block_word,
  output logic [smp_pkg::WORD_INDEX_W-1:0]  word_index,
  output logic                              init_block,
  output logic                              block_end,
  output logic                              run_end
);
  import smp_pkg::*;

  localparam int WORDS  = MAX_BLOCK_BYTES / 4;
  localparam int WORD_W = $clog2(WORDS);
  localparam int FILL_W = $clog2(MAX_BLOCK_BYTES + 1);

  logic [2:0]           mode;
  logic [FILL_W-1:0]    fill;
  logic [63:0]          byte_total;
  logic                 first_pending;
  logic [WORD_W-1:0]    word_cnt;
  logic [3:0][7:0]      mem [WORDS];
  logic [3:0][7:0]      rdata;

  logic                 wide_mode;
  logic [FILL_W-1:0]    bsize;
  logic [FILL_W-1:0]    fill_eff;
  logic [FILL_W:0]      fill_inc;
  logic [FILL_W+1:0]    need_len;
  logic [FILL_W+1:0]    len_size;
  logic [WORD_W-1:0]    last_idx;
  logic                 last_word;
  logic                 rd_go;
  logic [WORD_W-1:0]    rd_addr;
  logic [WORD_W-1:0]    wr_word;
  logic [1:0]           wr_lane;
  logic [63:0]          bit_count;
  logic [3:0][7:0]      fmt;
  logic [FILL_W:0]      pos;
  logic                 has_len;

  // Modes 4 to 7 use the large block; that is exactly the top mode bit.
  assign wide_mode = mode[2];
  assign bsize    = wide_mode ? FILL_W'(MAX_BLOCK_BYTES) : FILL_W'(SMALL_BLOCK_BYTES);
  // A fill left over from a larger mode is dropped.
  assign fill_eff = (fill >= bsize) ? '0 : fill;
  assign fill_inc = {1'b0, fill_eff} + 1'b1;
  assign len_size = wide_mode ? (FILL_W+2)'(LEN_FIELD_LARGE) : (FILL_W+2)'(LEN_FIELD_SMALL);
  assign need_len = {1'b0, fill_inc} + len_size;
  assign last_idx = wide_mode ? WORD_W'(WORDS - 1) : WORD_W'(SMALL_BLOCK_BYTES / 4 - 1);
  assign last_word = (word_cnt == last_idx);
  assign bit_count = {byte_total[60:0], 3'b000};
  assign has_len   = (cmd.kind == KIND_FINAL) || (cmd.kind == KIND_TAIL);

  assign status.blk_full   = (fill_inc == {1'b0, bsize});
  assign status.need_extra = (need_len > {2'b00, bsize});
  assign status.out_free   = ~out_valid | ~out_stall;
  assign status.last_word  = last_word;

  assign wr_word = fill_eff[WORD_W+1:2];
  assign wr_lane = fill_eff[1:0];
  assign rd_go   = cmd.rd_en | (cmd.load & ~last_word);
  assign rd_addr = cmd.load ? word_cnt + 1'b1 : word_cnt;

  // Block buffer: one byte written per message byte, one word read per cycle while the output is not stalled.
  always_ff @(posedge clk) begin
    if (cmd.accept_byte) begin
      mem[wr_word][~wr_lane] <= data_byte;
    end
    if (rd_go) begin
      rdata <= mem[rd_addr];
    end
  end

  // Padding is applied on the way out, so the buffer never needs clearing.
  always_comb begin
    pos = '0;
    for (int l = 0; l < 4; l++) begin
      pos = (FILL_W+1)'({word_cnt, l[1:0]});
      case (cmd.kind)
        KIND_DATA: begin
          fmt[3-l] = rdata[3-l];
        end
        KIND_PAD, KIND_FINAL: begin
          if (pos < {1'b0, fill}) begin
            fmt[3-l] = rdata[3-l];
          end else if (pos == {1'b0, fill}) begin
            fmt[3-l] = PAD_MARK;
          end else begin
            fmt[3-l] = 8'h00;
          end
        end
        default: begin
          fmt[3-l] = 8'h00;
        end
      endcase
    end
    if (has_len) begin
      if (word_cnt == last_idx - 1'b1) begin
        fmt = bit_count[63:32];
      end else if (last_word) begin
        fmt = bit_count[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= '0;
      fill          <= '0;
      byte_total    <= '0;
      first_pending <= 1'b1;
      word_cnt      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode <= hash_mode;
      end
      if (cmd.accept_byte) begin
        byte_total <= byte_total + 64'd1;
        fill       <= status.blk_full ? '0 : fill_inc[FILL_W-1:0];
      end
      if (cmd.accept_finish) begin
        fill <= fill_eff;
      end
      if (cmd.load) begin
        if (last_word) begin
          word_cnt      <= '0;
          // The final block of a message arms the flag for the next message.
          first_pending <= has_len;
          if (has_len) begin
            fill       <= '0;
            byte_total <= '0;
          end
        end else begin
          word_cnt <= word_cnt + 1'b1;
        end
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      block_word  <= fmt;
      word_index  <= WORD_INDEX_W'(word_cnt);
      init_block  <= first_pending;
      block_end   <= last_word;
      run_end     <= last_word & (cmd.kind != KIND_PAD);
    end
  end

endmodule

// ----- design/smp_checker.sv -----
`timescale 1ns / 1ps

module smp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              req_type,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [31:0]                       block_word,
  input logic [smp_pkg::WORD_INDEX_W-1:0]  word_index,
  input logic                              block_end,
  input logic                              run_end
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(block_word) && $stable(word_index))
    else $error("stalled result changed");

  // The last result of an item always closes a block.
  a_run_end_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_end |-> block_end)
    else $error("run_end without block_end");

  // A finish always produces a block, so intake must stop right after it.
  a_finish_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type |=> in_stall)
    else $error("finish transfer did not stop intake");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind sha_message_padder smp_checker u_smp_checker (.*);
